@@ src/wbt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbt_pkg
// Shared types, constants and helpers of the waypoint blend trajectory core.
// ----------------------------------------------------------------------------
package wbt_pkg;

	localparam int MAX_POINTS_DEF = 8;
	localparam logic [16:0] ONE_Q16 = 17'd65536;

	localparam logic [3:0]  COUNT_RST = 4'd5;
	localparam logic [14:0] HW_RST    = 15'd655;
	localparam logic [15:0] SCALE_RST = 16'd3277;

	localparam logic [1:0] REG_COUNT = 2'd0;
	localparam logic [1:0] REG_HW    = 2'd1;
	localparam logic [1:0] REG_SCALE = 2'd2;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// One waypoint as held in the table memory.
	typedef struct packed {
		logic [16:0]        t;
		logic signed [31:0] h;
		logic signed [31:0] y;
		logic signed [31:0] x;
	} wbt_entry_t;

	// Request to the shared multiply-divide unit: trunc(a * b / c).
	typedef struct packed {
		logic               start;
		logic signed [33:0] a;
		logic signed [34:0] b;
		logic signed [17:0] c;
	} wbt_mdreq_t;

	function automatic logic signed [31:0] field_sel(input wbt_entry_t e, input logic [1:0] f);
		logic signed [31:0] v;
		case (f)
			2'd0:    v = e.x;
			2'd1:    v = e.y;
			default: v = e.h;
		endcase
		return v;
	endfunction

endpackage

@@ src/wbt_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbt_mem
// Waypoint table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wbt_mem import wbt_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  wbt_entry_t    wdata,
	input  logic [AW-1:0] raddr,
	output wbt_entry_t    rdata
);

	wbt_entry_t mem [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/wbt_muldiv.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbt_muldiv
// Sequential signed trunc(a * b / c): shift-add multiply, then restoring
// division, one bit per cycle. The divisor must be non-zero.
// ----------------------------------------------------------------------------
module wbt_muldiv import wbt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  wbt_mdreq_t         req,
	output logic               done,
	output logic signed [68:0] q
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]  st_q;
	logic [6:0]  cnt_q;
	logic [67:0] mcand_q;
	logic [34:0] mplier_q;
	logic [67:0] prod_q;
	logic [17:0] dv_q;
	logic [17:0] rem_q;
	logic        neg_q;

	logic [33:0] abs_a;
	logic [34:0] abs_b;
	logic [17:0] abs_c;
	logic [18:0] trial;
	logic        ge;

	assign abs_a = req.a[33] ? 34'(-req.a) : 34'(req.a);
	assign abs_b = req.b[34] ? 35'(-req.b) : 35'(req.b);
	assign abs_c = req.c[17] ? 18'(-req.c) : 18'(req.c);
	assign trial = {rem_q, prod_q[67]};
	assign ge    = trial >= {1'b0, dv_q};

	assign done = (st_q == ST_DONE);
	assign q    = neg_q ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (req.start) begin
						st_q  <= ST_MUL;
						cnt_q <= '0;
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd34) begin
						st_q  <= ST_DIV;
						cnt_q <= '0;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd67) begin
						st_q <= ST_DONE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && req.start) begin
			mcand_q  <= {34'd0, abs_a};
			mplier_q <= abs_b;
			prod_q   <= '0;
			dv_q     <= abs_c;
			rem_q    <= '0;
			neg_q    <= req.a[33] ^ req.b[34] ^ req.c[17];
		end else if (st_q == ST_MUL) begin
			if (mplier_q[0]) begin
				prod_q <= prod_q + mcand_q;
			end
			mcand_q  <= {mcand_q[66:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[34:1]};
		end else if (st_q == ST_DIV) begin
			prod_q <= {prod_q[66:0], ge};
			rem_q  <= ge ? 18'(trial - {1'b0, dv_q}) : trial[17:0];
		end
	end

endmodule

@@ src/waypoint_blend_trajectory_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_blend_trajectory_core
// Trajectory through waypoints: straight segments with parabolic blends.
// ----------------------------------------------------------------------------
// Usage: items arrive on the s_ stream. tuser carries the kind: a load writes
// one waypoint into the table memory, rewinds progress to zero and turns
// recording on; it produces no result. A tick advances progress by the
// scaled elapsed time and produces at most one pose on the m_ stream.
// Registers are written over the cfg channel, which is always ready; write
// them only while the core is idle.
// Flow: a load is taken in the idle state. A tick is taken, searches the
// waypoints one by one, fetches three entries, then runs each quotient term
// through one shared sequential multiply-divide unit, with a step per field
// and one to hand over the pose. A straight segment costs three terms and a
// blend ten; a term over a zero time span is skipped, and a tick that finds
// no segment ends after its search. A tick after the end reads the last
// waypoint and hands it over as the pose. The pose waits in an output
// register; the next item is taken while it waits, but a further pose stalls
// until the receiver has taken the earlier one.
// Reset: progress is cleared, recording set, registers take their defaults.
// The table has no reset and must be loaded before it is used.
// ----------------------------------------------------------------------------
module waypoint_blend_trajectory_core import wbt_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// slot[2:0], point_x[34:3], point_y[66:35], point_heading[98:67],
	// point_time[115:99], elapsed[131:116], zero fill [135:132]
	input  logic [135:0] s_tdata,
	// kind[0]
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// x_pos[31:0], y_pos[63:32], heading[95:64]
	output logic [95:0]  m_tdata,
	// in_blend[0], finished[1], recorded[2]
	output logic [2:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SRCH_A = 4'd1;
	localparam logic [3:0] ST_SRCH_B = 4'd2;
	localparam logic [3:0] ST_F0     = 4'd3;
	localparam logic [3:0] ST_F1     = 4'd4;
	localparam logic [3:0] ST_F2     = 4'd5;
	localparam logic [3:0] ST_F3     = 4'd6;
	localparam logic [3:0] ST_RSQ    = 4'd7;
	localparam logic [3:0] ST_RSQ_W  = 4'd8;
	localparam logic [3:0] ST_TERM   = 4'd9;
	localparam logic [3:0] ST_TERM_W = 4'd10;
	localparam logic [3:0] ST_FIELD  = 4'd11;
	localparam logic [3:0] ST_FIN_A  = 4'd12;
	localparam logic [3:0] ST_FIN_B  = 4'd13;
	localparam logic [3:0] ST_EMIT   = 4'd14;

	// Configuration registers.
	logic [3:0]  count_q;
	logic [14:0] hw_q;
	logic [15:0] scale_q;

	// Control state.
	logic [3:0]    st_q;
	logic [16:0]   prog_q;
	logic          rec_q;
	logic [CW-1:0] idx_q;
	logic          blend_q;
	logic [1:0]    fld_q;
	logic [1:0]    term_q;

	// Working data.
	wbt_entry_t         e0_q, e1_q, e2_q;
	logic [32:0]        r_q;
	logic signed [71:0] acc_q;
	logic signed [31:0] res_q [3];
	logic               fin_q;
	logic               recout_q;

	// Output register.
	logic        ovalid_q;
	logic [95:0] odata_q;
	logic [2:0]  ouser_q;

	// Table memory ports.
	logic          mem_we;
	logic [AW-1:0] mem_raddr;
	wbt_entry_t    mem_wdata, mem_rdata;

	wbt_mdreq_t         md_req;
	logic               md_done;
	logic signed [68:0] md_q;

	logic [CW-1:0]      n_c;
	logic [31:0]        scaled;
	logic [17:0]        prog_sum;
	logic [16:0]        prog_new;
	logic               accept;
	logic [18:0]        hw_ext, prog_ext, ti_ext;
	logic signed [18:0] tau, u_val, s1, s2, pt0;
	logic signed [31:0] fv0, fv1, fv2;
	logic signed [32:0] d1, d2;
	logic               t_en, t_sub;
	logic               out_free;

	assign s_tready  = (st_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = ovalid_q;
	assign m_tdata   = odata_q;
	assign m_tuser   = ouser_q;
	assign out_free  = !ovalid_q || m_tready;

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RST;
			hw_q    <= HW_RST;
			scale_q <= SCALE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_COUNT: count_q <= cfg_data[3:0];
				REG_HW:    hw_q    <= cfg_data[14:0];
				REG_SCALE: scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Count of waypoints in use, clamped to 2..MAX_POINTS.
	always_comb begin
		if (32'(count_q) > MAX_POINTS) begin
			n_c = CW'(MAX_POINTS);
		end else if (count_q < 4'd2) begin
			n_c = CW'(2);
		end else begin
			n_c = CW'(count_q);
		end
	end

	// Progress advance for a tick while the end has not been reached.
	assign scaled   = scale_q * s_tdata[131:116];
	assign prog_sum = {1'b0, prog_q} + {2'b00, scaled[31:16]};
	assign prog_new = (prog_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : prog_sum[16:0];

	// Load items go straight into the table.
	assign mem_we    = accept && (s_tuser == KIND_LOAD) && (32'(s_tdata[2:0]) < MAX_POINTS);
	assign mem_wdata = {s_tdata[115:99], s_tdata[98:67], s_tdata[66:35], s_tdata[34:3]};

	always_comb begin
		unique case (st_q)
			ST_F0:    mem_raddr = AW'(idx_q - CW'(1));
			ST_F1:    mem_raddr = AW'(idx_q);
			ST_F2:    mem_raddr = AW'(idx_q + CW'(1));
			ST_FIN_A: mem_raddr = AW'(n_c - CW'(1));
			default:  mem_raddr = AW'(idx_q);
		endcase
	end

	wbt_mem #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (AW'(s_tdata[2:0])),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Times in a common 19-bit signed frame.
	assign hw_ext   = {4'd0, hw_q};
	assign prog_ext = {2'd0, prog_q};
	assign ti_ext   = {2'd0, mem_rdata.t};
	assign tau      = $signed(prog_ext) - $signed({2'd0, e1_q.t});
	assign u_val    = tau + $signed(hw_ext);
	assign pt0      = $signed(prog_ext) - $signed({2'd0, e0_q.t});
	assign s1       = $signed({2'd0, e1_q.t}) - $signed({2'd0, e0_q.t});
	assign s2       = $signed({2'd0, e2_q.t}) - $signed({2'd0, e1_q.t});

	assign fv0 = field_sel(e0_q, fld_q);
	assign fv1 = field_sel(e1_q, fld_q);
	assign fv2 = field_sel(e2_q, fld_q);
	assign d1  = $signed({fv1[31], fv1}) - $signed({fv0[31], fv0});
	assign d2  = $signed({fv2[31], fv2}) - $signed({fv1[31], fv1});

	// Operands of the current quotient term. The first term is the straight
	// segment (or the slope term of a blend), the other two the blend terms.
	always_comb begin
		md_req.start = 1'b0;
		md_req.a     = 34'(d1);
		md_req.b     = blend_q ? 35'(tau) : 35'(pt0);
		md_req.c     = 18'(s1);
		t_sub        = 1'b0;
		t_en         = (s1 != 19'sd0);
		if (st_q == ST_RSQ) begin
			md_req.a = 34'(u_val);
			md_req.b = 35'(u_val);
			md_req.c = {1'b0, (hw_q == 15'd0) ? 15'd1 : hw_q, 2'b00};
		end else begin
			case (term_q)
				2'd1: begin
					md_req.b = $signed({2'b00, r_q});
					t_sub    = 1'b1;
				end
				2'd2: begin
					md_req.a = 34'(d2);
					md_req.b = $signed({2'b00, r_q});
					md_req.c = 18'(s2);
					t_en     = (s2 != 19'sd0);
				end
				default: ;
			endcase
		end
		md_req.start = (st_q == ST_RSQ) || (st_q == ST_TERM && t_en);
	end

	wbt_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.done   (md_done),
		.q      (md_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			prog_q   <= '0;
			rec_q    <= 1'b1;
			idx_q    <= '0;
			blend_q  <= 1'b0;
			fld_q    <= '0;
			term_q   <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == KIND_LOAD) begin
							prog_q <= '0;
							rec_q  <= 1'b1;
						end else if (prog_q >= ONE_Q16) begin
							blend_q <= 1'b0;
							st_q    <= ST_FIN_A;
						end else begin
							prog_q <= prog_new;
							idx_q  <= CW'(1);
							st_q   <= ST_SRCH_A;
						end
					end
				end
				ST_SRCH_A: st_q <= ST_SRCH_B;
				ST_SRCH_B: begin
					if (ti_ext + hw_ext < prog_ext) begin
						if (idx_q + CW'(1) >= n_c) begin
							st_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + CW'(1);
							st_q  <= ST_SRCH_A;
						end
					end else begin
						blend_q <= !((idx_q == n_c - CW'(1)) || (ti_ext >= prog_ext + hw_ext));
						st_q    <= ST_F0;
					end
				end
				ST_F0: st_q <= ST_F1;
				ST_F1: st_q <= ST_F2;
				ST_F2: st_q <= ST_F3;
				ST_F3: begin
					fld_q  <= '0;
					term_q <= '0;
					st_q   <= blend_q ? ST_RSQ : ST_TERM;
				end
				ST_RSQ: st_q <= ST_RSQ_W;
				ST_RSQ_W: begin
					if (md_done) begin
						st_q <= ST_TERM;
					end
				end
				ST_TERM: begin
					if (t_en) begin
						st_q <= ST_TERM_W;
					end else if (!blend_q || term_q == 2'd2) begin
						st_q <= ST_FIELD;
					end else begin
						term_q <= term_q + 2'd1;
					end
				end
				ST_TERM_W: begin
					if (md_done) begin
						if (!blend_q || term_q == 2'd2) begin
							st_q <= ST_FIELD;
						end else begin
							term_q <= term_q + 2'd1;
							st_q   <= ST_TERM;
						end
					end
				end
				ST_FIELD: begin
					term_q <= '0;
					if (fld_q == 2'd2) begin
						st_q <= ST_EMIT;
					end else begin
						fld_q <= fld_q + 2'd1;
						st_q  <= ST_TERM;
					end
				end
				ST_FIN_A: st_q <= ST_FIN_B;
				ST_FIN_B: begin
					rec_q <= 1'b0;
					st_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// The output register is loaded when a pose is handed over and cleared
	// once the receiver has taken it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (st_q == ST_EMIT && out_free) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (st_q == ST_F1) e0_q <= mem_rdata;
		if (st_q == ST_F2) e1_q <= mem_rdata;
		if (st_q == ST_F3) e2_q <= mem_rdata;
		if (st_q == ST_RSQ_W && md_done) r_q <= md_q[32:0];
		// Accumulator starts each field at the segment's base point.
		if (st_q == ST_F3) begin
			acc_q <= 72'(blend_q ? e1_q.x : e0_q.x);
		end else if (st_q == ST_FIELD && fld_q != 2'd2) begin
			acc_q <= 72'(blend_q ? field_sel(e1_q, fld_q + 2'd1)
			                     : field_sel(e0_q, fld_q + 2'd1));
		end else if (st_q == ST_TERM_W && md_done) begin
			acc_q <= t_sub ? acc_q - 72'(md_q) : acc_q + 72'(md_q);
		end
		if (st_q == ST_FIELD) begin
			if (acc_q > 72'sd2147483647) begin
				res_q[fld_q] <= 32'sh7FFFFFFF;
			end else if (acc_q < -72'sd2147483648) begin
				res_q[fld_q] <= 32'sh80000000;
			end else begin
				res_q[fld_q] <= acc_q[31:0];
			end
			fin_q    <= (prog_q == ONE_Q16);
			recout_q <= rec_q;
		end
		if (st_q == ST_FIN_B) begin
			res_q[0] <= mem_rdata.x;
			res_q[1] <= mem_rdata.y;
			res_q[2] <= mem_rdata.h;
			fin_q    <= 1'b1;
			recout_q <= rec_q;
		end
		if (st_q == ST_EMIT && out_free) begin
			odata_q <= {res_q[2], res_q[1], res_q[0]};
			ouser_q <= {recout_q, fin_q, blend_q};
		end
	end

endmodule
